// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros shared by the triangle normal pipeline
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define TFN_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check on every clock edge, reset included
`define TFN_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg
// shared widths, defaults and sideband types of the triangle normal pipeline
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int COORD_WIDTH_DEF      = 24;
  localparam int NORMAL_FRAC_BITS_DEF = 14;

  // normalized cross product magnitudes stay below 2^31
  localparam int MAG_W    = 31;
  localparam int RAD_W    = 64;
  localparam int LEN_W    = 32;
  localparam int MINLEN_W = 20;
  localparam int OUT_W    = 16;

  localparam logic [MINLEN_W-1:0] MIN_LENGTH_RESET = 20'd4;

  typedef struct packed {
    logic [2:0]       neg;
    logic             s_zero;
    logic [MAG_W-1:0] mx;
    logic [MAG_W-1:0] my;
    logic [MAG_W-1:0] mz;
  } sq_side_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } div_side_t;

endpackage

// ===== rtl/triangle_face_normal.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal
// unit face normal of a triangle: cross product, length, per-component divide
// throughput: one item per cycle, busy stays low; 32 square root stages and
// NORMAL_FRAC_BITS + 1 divider stages set the depth
// reset clears all valid bits and sets min_length to 4
// ----------------------------------------------------------------------------
module triangle_face_normal #(
  parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_we,
  input  logic [tfn_pkg::MINLEN_W-1:0]      cfg_wdata,
  input  logic signed [COORD_WIDTH-1:0]     a_x,
  input  logic signed [COORD_WIDTH-1:0]     a_y,
  input  logic signed [COORD_WIDTH-1:0]     a_z,
  input  logic signed [COORD_WIDTH-1:0]     b_x,
  input  logic signed [COORD_WIDTH-1:0]     b_y,
  input  logic signed [COORD_WIDTH-1:0]     b_z,
  input  logic signed [COORD_WIDTH-1:0]     c_x,
  input  logic signed [COORD_WIDTH-1:0]     c_y,
  input  logic signed [COORD_WIDTH-1:0]     c_z,
  output logic                              done,
  output logic signed [tfn_pkg::OUT_W-1:0]  normal_x,
  output logic signed [tfn_pkg::OUT_W-1:0]  normal_y,
  output logic signed [tfn_pkg::OUT_W-1:0]  normal_z,
  output logic                              degenerate
);
  import tfn_pkg::*;

  localparam int F     = NORMAL_FRAC_BITS;
  localparam int EW    = COORD_WIDTH + 1;
  localparam int PW    = 2 * EW;
  localparam int CRW   = PW + 1;
  localparam int SH_W  = $clog2(PW + 1);
  localparam int SHV_W = (PW > MAG_W) ? PW : MAG_W;
  localparam int NUM_W = MAG_W + F + 1;
  localparam int QW    = F + 1;
  localparam int LAT   = 7 + LEN_W + 1 + QW + 1;

  logic [MINLEN_W-1:0] min_length;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RESET;
    end else if (cfg_we) begin
      min_length <= cfg_wdata;
    end
  end

  // cross product
  logic                  v3;
  logic signed [CRW-1:0] n_x, n_y, n_z;

  tfn_cross #(.CW(COORD_WIDTH)) u_cross (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .a_x      (a_x),
    .a_y      (a_y),
    .a_z      (a_z),
    .b_x      (b_x),
    .b_y      (b_y),
    .b_z      (b_z),
    .c_x      (c_x),
    .c_y      (c_y),
    .c_z      (c_z),
    .out_valid(v3),
    .n_x      (n_x),
    .n_y      (n_y),
    .n_z      (n_z)
  );

  // magnitudes
  logic          v4;
  logic [PW-1:0] mag_x, mag_y, mag_z;
  logic [2:0]    neg4;

  // leading-one shift and truncation to 31 bits
  logic             v5;
  logic [PW-1:0]    m_or;
  logic [SH_W-1:0]  hb, sh;
  logic [SHV_W-1:0] sh_x, sh_y, sh_z;
  sq_side_t         side5, side6, side7;

  // squares and sum
  logic                 v6, v7;
  logic [2*MAG_W-1:0]   sq_x, sq_y, sq_z;
  logic [RAD_W-1:0]     rad;

  always_comb begin
    m_or = mag_x | mag_y | mag_z;
    hb   = '0;
    for (int i = 0; i < PW; i++) begin
      if (m_or[i]) begin
        hb = SH_W'(i);
      end
    end
    if (hb >= SH_W'(MAG_W)) begin
      sh = hb - SH_W'(MAG_W - 1);
    end else begin
      sh = '0;
    end
    sh_x = SHV_W'(mag_x) >> sh;
    sh_y = SHV_W'(mag_y) >> sh;
    sh_z = SHV_W'(mag_z) >> sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    neg4  <= {n_z[CRW-1], n_y[CRW-1], n_x[CRW-1]};
    mag_x <= n_x[CRW-1] ? PW'(-n_x) : PW'(n_x);
    mag_y <= n_y[CRW-1] ? PW'(-n_y) : PW'(n_y);
    mag_z <= n_z[CRW-1] ? PW'(-n_z) : PW'(n_z);

    side5.neg    <= neg4;
    side5.s_zero <= (sh == '0);
    side5.mx     <= sh_x[MAG_W-1:0];
    side5.my     <= sh_y[MAG_W-1:0];
    side5.mz     <= sh_z[MAG_W-1:0];

    side6 <= side5;
    sq_x  <= side5.mx * side5.mx;
    sq_y  <= side5.my * side5.my;
    sq_z  <= side5.mz * side5.mz;

    side7 <= side6;
    rad   <= RAD_W'(sq_x) + RAD_W'(sq_y) + RAD_W'(sq_z);
  end

  // square root
  logic             vs;
  logic [LEN_W-1:0] len;
  sq_side_t         sides;

  tfn_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v7),
    .radicand (rad),
    .in_side  (side7),
    .out_valid(vs),
    .root     (len),
    .out_side (sides)
  );

  // rounding offset and degenerate test
  logic                  vp;
  logic [2:0][NUM_W-1:0] num;
  logic [LEN_W-1:0]      den;
  div_side_t             sidep;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else begin
      vp <= vs;
    end
  end

  always_ff @(posedge clk) begin
    num[0]      <= (NUM_W'(sides.mx) << F) + NUM_W'(len >> 1);
    num[1]      <= (NUM_W'(sides.my) << F) + NUM_W'(len >> 1);
    num[2]      <= (NUM_W'(sides.mz) << F) + NUM_W'(len >> 1);
    den         <= len;
    sidep.neg   <= sides.neg;
    sidep.degen <= (len == '0) || (sides.s_zero && (len < LEN_W'(min_length)));
  end

  // division
  logic               vd;
  logic [2:0][QW-1:0] quo;
  div_side_t          sided;

  tfn_div #(.FRAC(F)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vp),
    .num      (num),
    .den      (den),
    .in_side  (sidep),
    .out_valid(vd),
    .quo      (quo),
    .out_side (sided)
  );

  // saturate, apply sign, keep the low field bits
  localparam logic [QW-1:0] ONE    = QW'(1) << F;
  localparam logic [63:0]   ONE_64 = 64'(1) << F;

  logic [2:0][QW-1:0] qs;
  logic [2:0][63:0]   qw;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qs[l] = (quo[l] > ONE) ? ONE : quo[l];
      qw[l] = sided.neg[l] ? (64'(0) - 64'(qs[l])) : 64'(qs[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd;
    end
  end

  always_ff @(posedge clk) begin
    degenerate <= sided.degen;
    if (sided.degen) begin
      normal_x <= '0;
      normal_y <= ONE_64[OUT_W-1:0];
      normal_z <= '0;
    end else begin
      normal_x <= qw[0][OUT_W-1:0];
      normal_y <= qw[1][OUT_W-1:0];
      normal_z <= qw[2][OUT_W-1:0];
    end
  end

`include "assert_macros.svh"

  `TFN_CHECK(a_latency, done == $past(start && !busy && !rst, LAT), "item lost or invented")
  `TFN_CHECK(a_degen_xz, !(done && degenerate) || (normal_x == '0 && normal_z == '0),
             "fallback normal has nonzero x or z")
  `TFN_CHECK(a_degen_y, !(done && degenerate) || (normal_y == ONE_64[OUT_W-1:0]),
             "fallback normal y is not one")

endmodule

// ===== rtl/tfn_cross.sv =====
// ----------------------------------------------------------------------------
// tfn_cross
// three-stage edge difference, product and cross product pipeline
// ----------------------------------------------------------------------------
module tfn_cross #(
  parameter int CW = tfn_pkg::COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] a_x,
  input  logic signed [CW-1:0] a_y,
  input  logic signed [CW-1:0] a_z,
  input  logic signed [CW-1:0] b_x,
  input  logic signed [CW-1:0] b_y,
  input  logic signed [CW-1:0] b_z,
  input  logic signed [CW-1:0] c_x,
  input  logic signed [CW-1:0] c_y,
  input  logic signed [CW-1:0] c_z,
  output logic                 out_valid,
  output logic signed [2*CW+2:0] n_x,
  output logic signed [2*CW+2:0] n_y,
  output logic signed [2*CW+2:0] n_z
);
  import tfn_pkg::*;

  localparam int EW  = CW + 1;
  localparam int PW  = 2 * EW;
  localparam int CRW = PW + 1;

  logic signed [EW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
  logic                 v1, v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    e1x <= EW'(b_x) - EW'(a_x);
    e1y <= EW'(b_y) - EW'(a_y);
    e1z <= EW'(b_z) - EW'(a_z);
    e2x <= EW'(c_x) - EW'(a_x);
    e2y <= EW'(c_y) - EW'(a_y);
    e2z <= EW'(c_z) - EW'(a_z);

    p0 <= e1y * e2z;
    p1 <= e1z * e2y;
    p2 <= e1z * e2x;
    p3 <= e1x * e2z;
    p4 <= e1x * e2y;
    p5 <= e1y * e2x;

    n_x <= CRW'(p0) - CRW'(p1);
    n_y <= CRW'(p2) - CRW'(p3);
    n_z <= CRW'(p4) - CRW'(p5);
  end

endmodule

// ===== rtl/tfn_sqrt.sv =====
// ----------------------------------------------------------------------------
// tfn_sqrt
// integer square root, one result bit per pipeline stage
// ----------------------------------------------------------------------------
module tfn_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [tfn_pkg::RAD_W-1:0]   radicand,
  input  tfn_pkg::sq_side_t           in_side,
  output logic                        out_valid,
  output logic [tfn_pkg::LEN_W-1:0]   root,
  output tfn_pkg::sq_side_t           out_side
);
  import tfn_pkg::*;

  localparam int IW = RAD_W;
  localparam int OW = LEN_W;

  logic [IW-1:0] rem_q  [OW];
  logic [OW-1:0] root_q [OW];
  logic          vld_q  [OW];
  sq_side_t      side_q [OW];

  for (genvar k = 0; k < OW; k++) begin : g_st
    localparam int B = OW - 1 - k;
    logic [IW-1:0] rem_in;
    logic [OW-1:0] root_in;
    logic          vld_in;
    sq_side_t      side_in;
    logic [IW:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in  = radicand;
      assign root_in = '0;
      assign vld_in  = in_valid;
      assign side_in = in_side;
    end else begin : g_rest
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign vld_in  = vld_q[k-1];
      assign side_in = side_q[k-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = ((IW+1)'(root_in) << (B + 1)) + ((IW+1)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      side_q[k] <= side_in;
      if ((IW+1)'(rem_in) >= trial) begin
        rem_q[k]  <= IW'((IW+1)'(rem_in) - trial);
        root_q[k] <= root_in | (OW'(1) << B);
      end else begin
        rem_q[k]  <= rem_in;
        root_q[k] <= root_in;
      end
    end
  end

  assign out_valid = vld_q[OW-1];
  assign root      = root_q[OW-1];
  assign out_side  = side_q[OW-1];

endmodule

// ===== rtl/tfn_div.sv =====
// ----------------------------------------------------------------------------
// tfn_div
// three-lane restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
module tfn_div #(
  parameter int FRAC = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic [2:0][tfn_pkg::MAG_W+FRAC:0]    num,
  input  logic [tfn_pkg::LEN_W-1:0]            den,
  input  tfn_pkg::div_side_t                   in_side,
  output logic                                 out_valid,
  output logic [2:0][FRAC:0]                   quo,
  output tfn_pkg::div_side_t                   out_side
);
  import tfn_pkg::*;

  localparam int NUM_W = MAG_W + FRAC + 1;
  localparam int QW    = FRAC + 1;

  logic [2:0][NUM_W-1:0] rem_q  [QW];
  logic [2:0][QW-1:0]    quo_q  [QW];
  logic [LEN_W-1:0]      den_q  [QW];
  logic                  vld_q  [QW];
  div_side_t             side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    localparam int B = QW - 1 - k;
    logic [2:0][NUM_W-1:0] rem_in;
    logic [2:0][QW-1:0]    quo_in;
    logic [LEN_W-1:0]      den_in;
    logic                  vld_in;
    div_side_t             side_in;
    logic [NUM_W-1:0]      dsh;

    if (k == 0) begin : g_first
      assign rem_in  = num;
      assign quo_in  = '0;
      assign den_in  = den;
      assign vld_in  = in_valid;
      assign side_in = in_side;
    end else begin : g_rest
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign vld_in  = vld_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign dsh = NUM_W'(den_in) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      den_q[k]  <= den_in;
      side_q[k] <= side_in;
      for (int l = 0; l < 3; l++) begin
        if (rem_in[l] >= dsh) begin
          rem_q[k][l] <= rem_in[l] - dsh;
          quo_q[k][l] <= quo_in[l] | (QW'(1) << B);
        end else begin
          rem_q[k][l] <= rem_in[l];
          quo_q[k][l] <= quo_in[l];
        end
      end
    end
  end

  assign out_valid = vld_q[QW-1];
  assign quo       = quo_q[QW-1];
  assign out_side  = side_q[QW-1];

endmodule
